[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds on every clock edge outside reset
`define AST_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// check that a condition implies another one in the following cycle
`define AST_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/sbhc_pkg.sv]
`timescale 1ns / 1ps

package sbhc_pkg;

   localparam int NUM_BINS = 4096;
   localparam int BIN_AW   = $clog2(NUM_BINS);

   localparam int CSR_DW   = 25;
   localparam int CSR_IW   = 2;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_LOW   = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_RECIP = 2'd2;

   // spectrum modes
   localparam logic [1:0] MODE_LIVE = 2'd0;
   localparam logic [1:0] MODE_PEAK = 2'd1;
   localparam logic [1:0] MODE_AVG  = 2'd2;

   localparam logic [24:0] RECIP_RESET = 25'd256;

   // segment bounds of the color scale, unsigned Q16
   localparam logic [15:0] SEG1 = 16'd14564;
   localparam logic [15:0] SEG2 = 16'd21845;
   localparam logic [15:0] SEG3 = 16'd29127;
   localparam logic [15:0] SEG4 = 16'd36409;
   localparam logic [15:0] SEG5 = 16'd50972;
   localparam logic [15:0] SEG6 = 16'd58254;

   typedef struct packed {
      logic [11:0]        bin_index;
      logic signed [15:0] level;
   } req_type;

   typedef struct packed {
      logic signed [15:0] held_level;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } rsp_type;

endpackage

[rtl/core/spectrum_bin_hold_and_colormap.sv]
`timescale 1ns / 1ps
// Spectrum bin hold and waterfall color map.
// req channel: one transaction per spectrum bin (bin_index, level in Q8.8).
// rsp channel: one transaction per request, in order: the held level
//   (live, peak hold or exponential average, per spectrum_mode) and the RGB
//   waterfall pixel of the raw level.
// csr port: write enable, index and data; index 0 mode, 1 low level,
//   2 reciprocal of the color span. Write only while no request is in flight.
// A request passes through the compute stage and the output register. Throughput: one bin per
//   cycle while req_stall is low, set by the read-modify-write of the bin memory; a
//   hit on the bin just written is forwarded.
// Reset, and every mode write, starts a pass that clears the valid bit of
//   all 4096 bins, one per cycle: req_stall stays high until the pass ends.
// A stalled response holds in the output register; one more request waits
//   in the compute stage, after which req_stall rises.
`include "assert_macros.svh"

module spectrum_bin_hold_and_colormap (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sbhc_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sbhc_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [sbhc_pkg::CSR_IW-1:0]  csr_index,
   input  logic [sbhc_pkg::CSR_DW-1:0]  csr_wdata
);

   localparam int AW = sbhc_pkg::BIN_AW;
   localparam logic [AW-1:0] LAST_BIN = AW'(sbhc_pkg::NUM_BINS - 1);

   // configuration
   logic [1:0]         mode_ff;
   logic signed [15:0] low_ff;
   logic [24:0]        recip_ff;

   // clearing pass
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   // bin memory: {valid, level}
   logic [16:0]   bin_ram [sbhc_pkg::NUM_BINS];
   logic [16:0]   rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [16:0]   mem_wdata;

   // compute stage
   logic               s1_valid_ff;
   logic [AW-1:0]      s1_idx_ff;
   logic signed [15:0] s1_level_ff;
   logic               s1_black_ff;
   logic               s1_yellow_ff;
   logic [15:0]        s1_p_ff;
   logic               fwd_hit_ff;
   logic [16:0]        fwd_data_ff;

   // output register
   logic              rsp_valid_ff;
   sbhc_pkg::rsp_type rsp_data_ff;

   logic req_fire;
   logic s1_fire;
   logic wb_we;

   logic [AW-1:0]      req_idx;
   logic signed [16:0] diff;
   logic               diff_nonpos;
   logic [40:0]        prod;
   logic [32:0]        p_full;

   logic [16:0]        old_entry;
   logic signed [15:0] old_level;
   logic signed [25:0] avg_sum;
   logic signed [15:0] held;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;

   function automatic logic [7:0] ramp_up(input logic [15:0] d, input logic half);
      logic [27:0] p;
      logic [27:0] s;
      p = 28'(d) * 28'd2295;
      s = half ? (p >> 17) : (p >> 16);
      return (s > 28'd255) ? 8'd255 : s[7:0];
   endfunction

   // ((base - 9*d) * 255) >> (16 + k), base = 2^(16 + k), floored at zero
   function automatic logic [7:0] falling(input logic [15:0] d, input logic [1:0] k);
      logic [19:0] base;
      logic [19:0] nd;
      logic [19:0] rem;
      logic [27:0] p;
      logic [27:0] s;
      base = 20'd65536 << k;
      nd   = 20'(d) * 20'd9;
      rem  = base - nd;
      p    = 28'(rem) * 28'd255;
      unique case (k)
         2'd0:    s = p >> 16;
         2'd1:    s = p >> 17;
         default: s = p >> 18;
      endcase
      if (nd >= base) begin
         return 8'd0;
      end
      return (s > 28'd255) ? 8'd255 : s[7:0];
   endfunction

   assign req_idx   = req_data.bin_index[AW-1:0];
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr_active_ff || (s1_valid_ff && !s1_fire);
   assign req_fire  = req_valid && !req_stall;
   assign wb_we     = s1_fire && (mode_ff == sbhc_pkg::MODE_PEAK ||
                                  mode_ff == sbhc_pkg::MODE_AVG);

   // configuration and clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= sbhc_pkg::MODE_LIVE;
         low_ff        <= '0;
         recip_ff      <= sbhc_pkg::RECIP_RESET;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_BIN) begin
               clr_active_ff <= 1'b0;
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               sbhc_pkg::CSR_MODE: begin
                  mode_ff       <= csr_wdata[1:0];
                  clr_active_ff <= 1'b1;
                  clr_addr_ff   <= '0;
               end
               sbhc_pkg::CSR_LOW:   low_ff   <= csr_wdata[15:0];
               sbhc_pkg::CSR_RECIP: recip_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // color scale percent, computed ahead of the compute stage
   always_comb begin
      diff        = 17'(req_data.level) - 17'(low_ff);
      diff_nonpos = diff[16] || (diff == 17'sd0);
      prod        = 41'(diff[15:0]) * 41'(recip_ff);
      p_full      = prod[40:8];
   end

   // memory write port: clearing pass or write-back
   always_comb begin
      if (clr_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wb_we;
         mem_waddr = s1_idx_ff;
         mem_wdata = {1'b1, held};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_ram[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_ff <= bin_ram[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_idx_ff    <= req_idx;
         s1_level_ff  <= req_data.level;
         s1_black_ff  <= diff_nonpos || (p_full == 33'd0);
         s1_yellow_ff <= |p_full[32:16];
         s1_p_ff      <= p_full[15:0];
         // same bin written back at this edge: memory returns the old word
         fwd_hit_ff   <= wb_we && (s1_idx_ff == req_idx);
         fwd_data_ff  <= {1'b1, held};
      end
   end

   // held level
   always_comb begin
      old_entry = fwd_hit_ff ? fwd_data_ff : rd_ff;
      old_level = old_entry[15:0];
      avg_sum   = 26'(s1_level_ff) * 26'sd77 + 26'(old_level) * 26'sd179 + 26'sd128;
      held      = s1_level_ff;
      if (old_entry[16]) begin
         if (mode_ff == sbhc_pkg::MODE_PEAK) begin
            held = (old_level > s1_level_ff) ? old_level : s1_level_ff;
         end else if (mode_ff == sbhc_pkg::MODE_AVG) begin
            held = avg_sum[23:8];
         end
      end
   end

   // nine-segment waterfall map
   always_comb begin
      red   = 8'd0;
      green = 8'd0;
      blue  = 8'd0;
      priority if (s1_black_ff) begin
      end else if (s1_yellow_ff) begin
         red   = 8'd255;
         green = 8'd255;
      end else if (s1_p_ff < sbhc_pkg::SEG1) begin
         blue  = ramp_up(s1_p_ff, 1'b1);
      end else if (s1_p_ff < sbhc_pkg::SEG2) begin
         green = ramp_up(s1_p_ff - sbhc_pkg::SEG1, 1'b0);
         blue  = 8'd255;
      end else if (s1_p_ff < sbhc_pkg::SEG3) begin
         green = 8'd255;
         blue  = falling(s1_p_ff - sbhc_pkg::SEG2, 2'd0);
      end else if (s1_p_ff < sbhc_pkg::SEG4) begin
         red   = ramp_up(s1_p_ff - sbhc_pkg::SEG3, 1'b0);
         green = 8'd255;
      end else if (s1_p_ff < sbhc_pkg::SEG5) begin
         red   = 8'd255;
         green = falling(s1_p_ff - sbhc_pkg::SEG4, 2'd1);
      end else if (s1_p_ff < sbhc_pkg::SEG6) begin
         red   = 8'd255;
         blue  = ramp_up(s1_p_ff - sbhc_pkg::SEG5, 1'b0);
      end else begin
         red   = falling(s1_p_ff - sbhc_pkg::SEG6, 2'd2);
         green = ramp_up(s1_p_ff - sbhc_pkg::SEG6, 1'b1);
         blue  = 8'd255;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff.held_level <= held;
         rsp_data_ff.red        <= red;
         rsp_data_ff.green      <= green;
         rsp_data_ff.blue       <= blue;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `AST_NEXT(a_mode_write_clears, csr_we && (csr_index == sbhc_pkg::CSR_MODE), clr_active_ff, "mode write did not start clearing pass")
   `AST_ALWAYS(a_peak_not_below, !(s1_fire && mode_ff == sbhc_pkg::MODE_PEAK) || (held >= s1_level_ff), "peak hold below input level")
   `AST_NEXT(a_accept_loads_stage, req_fire, s1_valid_ff, "accepted transaction lost before compute stage")

endmodule
